### design/fsac_pkg.sv
// Package with shared types and constants of the Forth stack ALU core.
`timescale 1ns / 1ps
package fsac_pkg;

  localparam int unsigned DATA_DEPTH   = 16;
  localparam int unsigned RETURN_DEPTH = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned ACTION_W     = 5;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned STATUS_W     = 3;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DUP, ACT_DROP, ACT_SWAP, ACT_OVER, ACT_ADD, ACT_SUB, ACT_AND, ACT_OR,
    ACT_XOR, ACT_INVERT, ACT_NEGATE, ACT_ABS, ACT_SHL1, ACT_SHR1, ACT_LSHIFT,
    ACT_RSHIFT, ACT_UMUL, ACT_UDIVMOD, ACT_DNEGATE, ACT_NIP, ACT_DEPTH,
    ACT_LITERAL, ACT_TOR, ACT_RFROM, ACT_RFETCH, ACT_RESET
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_UNDER, ST_OVER, ST_DIVZ, ST_QOVF
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_DONE
  } state_e;

  // Control from the sequencer to the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

endpackage

### design/fsac_in_if.sv
// Input channel interface carrying one action item.
`timescale 1ns / 1ps
interface fsac_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsac_pkg::ACTION_W-1:0] action;
  logic [fsac_pkg::WORD_W-1:0]   literal;

  modport source (output valid, output action, output literal, input ready);
  modport sink (input valid, input action, input literal, output ready);
endinterface

### design/fsac_out_if.sv
// Output channel interface carrying one result item.
`timescale 1ns / 1ps
interface fsac_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsac_pkg::WORD_W-1:0]   top_value;
  logic [fsac_pkg::WORD_W-1:0]   second_value;
  logic [fsac_pkg::COUNT_W-1:0]  data_count;
  logic [fsac_pkg::COUNT_W-1:0]  return_count;
  logic [fsac_pkg::STATUS_W-1:0] status;

  modport source (output valid, output top_value, output second_value, output data_count,
                  output return_count, output status, input ready);
  modport sink (input valid, input top_value, input second_value, input data_count,
                input return_count, input status, output ready);
endinterface

### design/forth_stack_alu_core.sv
// Top level of the Forth stack ALU core: sequencer, cached top and second, stacks.
// Each item passes the read, execute and done states, with a wait state for umul and
// udivmod on the bit-serial multiply/divide unit; the next item is taken only back in idle,
// but it is accepted while the previous result still waits at the output register.
// Reset: asynchronous active low; clears top, counts and control; stack memories
// are not cleared.
`timescale 1ns / 1ps
module forth_stack_alu_core #(
  parameter int unsigned DataDepth = fsac_pkg::DATA_DEPTH,
  parameter int unsigned RetDepth  = fsac_pkg::RETURN_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsac_in_if.sink     in_i,
  fsac_out_if.source  out_o
);

  localparam int unsigned AW  = $clog2(DataDepth);
  localparam int unsigned PW  = $clog2(DataDepth + 1);
  localparam int unsigned RAW = $clog2(RetDepth);
  localparam int unsigned RPW = $clog2(RetDepth + 1);

  fsac_pkg::state_e  state_q, state_d;
  fsac_pkg::action_e act_q;
  fsac_pkg::status_e st_q, st_d;
  logic [31:0]       lit_q, top_q, top_d, sec_q, sec_d;
  logic [PW-1:0]     dp_q, dp_d, dp_m1, dp_m2;
  logic [RPW-1:0]    rp_q, rp_d, rp_m1;
  logic              ov_q, load_out;

  logic              dwe, rwe;
  logic [AW-1:0]     dwaddr;
  logic [RAW-1:0]    rwaddr;
  logic [31:0]       m2, rv, rwdata;

  fsac_pkg::md_ctl_t md_ctl;
  logic [63:0]       md_opa;
  logic [31:0]       md_opb, md_acc;
  logic [63:0]       md_quo;
  logic              md_done;

  assign dp_m1 = dp_q - PW'(1);
  assign dp_m2 = dp_q - PW'(2);
  assign rp_m1 = rp_q - RPW'(1);

  fsac_ram #(.Depth(DataDepth)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dwe),
    .waddr_i(dwaddr),
    .wdata_i(sec_q),
    .raddr_i(dp_m2[AW-1:0]),
    .rdata_o(m2)
  );

  fsac_ram #(.Depth(RetDepth)) u_ret_ram (
    .clk_i  (clk_i),
    .we_i   (rwe),
    .waddr_i(rwaddr),
    .wdata_i(rwdata),
    .raddr_i(rp_m1[RAW-1:0]),
    .rdata_o(rv)
  );

  fsac_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (md_ctl),
    .opa_i (md_opa),
    .opb_i (md_opb),
    .done_o(md_done),
    .acc_o (md_acc),
    .quo_o (md_quo)
  );

  assign in_i.ready = (state_q == fsac_pkg::S_IDLE);
  assign md_opa     = (act_q == fsac_pkg::ACT_UDIVMOD) ? {sec_q, m2} : {32'd0, top_q};
  assign md_opb     = (act_q == fsac_pkg::ACT_UDIVMOD) ? top_q : sec_q;

  // Sequencer and action execution.
  always_comb begin
    logic        under1, under2, full, rfull, do_push, do_pop;
    logic [31:0] push_val, r;
    logic [63:0] dneg;
    under1   = (dp_q == '0);
    under2   = (dp_q < PW'(2));
    full     = (dp_q >= PW'(DataDepth));
    rfull    = (rp_q >= RPW'(RetDepth));
    do_push  = 1'b0;
    do_pop   = 1'b0;
    push_val = top_q;
    dneg     = 64'd0 - {top_q, sec_q};
    state_d  = state_q;
    top_d    = top_q;
    sec_d    = sec_q;
    dp_d     = dp_q;
    rp_d     = rp_q;
    st_d     = st_q;
    dwe      = 1'b0;
    dwaddr   = dp_m1[AW-1:0];
    rwe      = 1'b0;
    rwaddr   = rp_q[RAW-1:0];
    rwdata   = top_q;
    md_ctl   = '0;
    load_out = 1'b0;

    // Binary ALU result, second op top.
    case (act_q)
      fsac_pkg::ACT_ADD: r = sec_q + top_q;
      fsac_pkg::ACT_SUB: r = sec_q - top_q;
      fsac_pkg::ACT_AND: r = sec_q & top_q;
      fsac_pkg::ACT_OR:  r = sec_q | top_q;
      fsac_pkg::ACT_XOR: r = sec_q ^ top_q;
      fsac_pkg::ACT_LSHIFT: r = (|top_q[31:5]) ? 32'd0 : sec_q << top_q[4:0];
      default: r = (|top_q[31:5]) ? 32'd0 : sec_q >> top_q[4:0];
    endcase

    unique case (state_q)
      fsac_pkg::S_IDLE: begin
        if (in_i.valid) begin
          state_d = fsac_pkg::S_READ;
        end
      end
      fsac_pkg::S_READ: begin
        state_d = fsac_pkg::S_EXEC;
      end
      fsac_pkg::S_EXEC: begin
        state_d = fsac_pkg::S_DONE;
        st_d    = fsac_pkg::ST_OK;
        case (act_q)
          fsac_pkg::ACT_DUP, fsac_pkg::ACT_DEPTH, fsac_pkg::ACT_LITERAL: begin
            if (full) begin
              st_d = fsac_pkg::ST_OVER;
            end else begin
              do_push  = 1'b1;
              push_val = (act_q == fsac_pkg::ACT_DUP) ? top_q :
                         (act_q == fsac_pkg::ACT_DEPTH) ? 32'(dp_q) : lit_q;
            end
          end
          fsac_pkg::ACT_DROP: begin
            if (under1) st_d = fsac_pkg::ST_UNDER;
            else do_pop = 1'b1;
          end
          fsac_pkg::ACT_SWAP: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else begin
              sec_d = top_q;
              top_d = sec_q;
            end
          end
          fsac_pkg::ACT_OVER: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else if (full) begin
              st_d = fsac_pkg::ST_OVER;
            end else begin
              do_push  = 1'b1;
              push_val = sec_q;
            end
          end
          fsac_pkg::ACT_ADD, fsac_pkg::ACT_SUB, fsac_pkg::ACT_AND, fsac_pkg::ACT_OR,
          fsac_pkg::ACT_XOR, fsac_pkg::ACT_LSHIFT, fsac_pkg::ACT_RSHIFT: begin
            if (under1) st_d = fsac_pkg::ST_UNDER;
            else do_pop = 1'b1;
          end
          fsac_pkg::ACT_INVERT: top_d = ~top_q;
          fsac_pkg::ACT_NEGATE: top_d = 32'd0 - top_q;
          fsac_pkg::ACT_ABS: begin
            if ((top_q & fsac_pkg::SIGN_BIT) != 32'd0) top_d = 32'd0 - top_q;
          end
          fsac_pkg::ACT_SHL1: top_d = {top_q[30:0], 1'b0};
          fsac_pkg::ACT_SHR1: top_d = {1'b0, top_q[31:1]};
          fsac_pkg::ACT_UMUL: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else begin
              md_ctl.start = 1'b1;
              state_d      = fsac_pkg::S_WAIT;
            end
          end
          fsac_pkg::ACT_UDIVMOD: begin
            if (under2) begin
              st_d = fsac_pkg::ST_UNDER;
            end else if (top_q == 32'd0) begin
              st_d = fsac_pkg::ST_DIVZ;
            end else begin
              md_ctl.start  = 1'b1;
              md_ctl.is_div = 1'b1;
              state_d       = fsac_pkg::S_WAIT;
            end
          end
          fsac_pkg::ACT_DNEGATE: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else begin
              top_d = dneg[63:32];
              sec_d = dneg[31:0];
            end
          end
          fsac_pkg::ACT_NIP: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else begin
              dp_d  = dp_m1;
              sec_d = m2;
            end
          end
          fsac_pkg::ACT_TOR: begin
            if (under1) begin
              st_d = fsac_pkg::ST_UNDER;
            end else if (rfull) begin
              st_d = fsac_pkg::ST_OVER;
            end else begin
              rwe    = 1'b1;
              rp_d   = rp_q + RPW'(1);
              do_pop = 1'b1;
            end
          end
          fsac_pkg::ACT_RFROM, fsac_pkg::ACT_RFETCH: begin
            if (rp_q == '0) begin
              st_d = fsac_pkg::ST_UNDER;
            end else if (full) begin
              st_d = fsac_pkg::ST_OVER;
            end else begin
              do_push  = 1'b1;
              push_val = rv;
              if (act_q == fsac_pkg::ACT_RFROM) rp_d = rp_m1;
            end
          end
          fsac_pkg::ACT_RESET: begin
            top_d = 32'd0;
            dp_d  = '0;
            rp_d  = '0;
          end
          default: ;
        endcase
        // Stack moves shared by several actions.
        if (do_push) begin
          dwe   = (dp_q != '0);
          sec_d = top_q;
          top_d = push_val;
          dp_d  = dp_q + PW'(1);
        end
        if (do_pop) begin
          dp_d  = dp_m1;
          sec_d = m2;
          top_d = (act_q == fsac_pkg::ACT_DROP || act_q == fsac_pkg::ACT_TOR) ? sec_q : r;
        end
      end
      fsac_pkg::S_WAIT: begin
        if (md_done) begin
          state_d = fsac_pkg::S_DONE;
          if (act_q == fsac_pkg::ACT_UDIVMOD) begin
            dp_d  = dp_m1;
            sec_d = md_acc;
            top_d = md_quo[31:0];
            if (md_quo[63:32] != 32'd0) st_d = fsac_pkg::ST_QOVF;
          end else begin
            sec_d = md_quo[31:0];
            top_d = md_acc;
          end
        end
      end
      fsac_pkg::S_DONE: begin
        if (!ov_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = fsac_pkg::S_IDLE;
        end
      end
      default: state_d = fsac_pkg::S_IDLE;
    endcase
  end

  // State register and stack control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsac_pkg::S_IDLE;
      top_q   <= '0;
      dp_q    <= '0;
      rp_q    <= '0;
      st_q    <= fsac_pkg::ST_OK;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      dp_q    <= dp_d;
      rp_q    <= rp_d;
      st_q    <= st_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  // Payload registers: second, accepted item and output.
  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
    if (in_i.valid && in_i.ready) begin
      act_q <= fsac_pkg::action_e'(in_i.action);
      lit_q <= in_i.literal;
    end
    if (load_out) begin
      out_o.top_value    <= top_q;
      out_o.second_value <= (dp_q == '0) ? 32'd0 : sec_q;
      out_o.data_count   <= 5'(dp_q);
      out_o.return_count <= 5'(rp_q);
      out_o.status       <= st_q;
    end
  end

  assign out_o.valid = ov_q;

  // Counts never exceed the stack depths.
  a_dp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_q <= PW'(DataDepth)) else $error("data count beyond depth");
  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= RPW'(RetDepth)) else $error("return count beyond depth");
  // An accepted item starts with the read cycle.
  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == fsac_pkg::S_READ)
    else $error("accepted item did not enter read state");
  // The multiply/divide unit finishes only while the sequencer waits for it.
  a_md_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> state_q == fsac_pkg::S_WAIT) else $error("unit done outside wait");

endmodule

### design/fsac_ram.sv
// Stack memory with one write port and one registered read port.
`timescale 1ns / 1ps
module fsac_ram #(
  parameter int unsigned Depth = fsac_pkg::DATA_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [fsac_pkg::WORD_W-1:0] wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [fsac_pkg::WORD_W-1:0] rdata_o
);

  logic [fsac_pkg::WORD_W-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/fsac_muldiv.sv
// Iterative unit: shift-add multiply and restoring 64/32 divide on one adder.
`timescale 1ns / 1ps
module fsac_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsac_pkg::md_ctl_t ctl_i,
  input  logic [63:0]       opa_i,
  input  logic [31:0]       opb_i,
  output logic              done_o,
  output logic [31:0]       acc_o,
  output logic [63:0]       quo_o
);

  logic        busy_q, div_q;
  logic [6:0]  cnt_q;
  logic [31:0] acc_q, b_q;
  logic [63:0] q_q;
  logic [32:0] add_a, add_b;
  logic        add_c;
  logic [33:0] sum;

  // Shared adder: accumulate for multiply, trial subtract for divide.
  always_comb begin
    if (div_q) begin
      add_a = {acc_q, q_q[63]};
      add_b = ~{1'b0, b_q};
      add_c = 1'b1;
    end else begin
      add_a = {1'b0, acc_q};
      add_b = q_q[0] ? {1'b0, b_q} : 33'd0;
      add_c = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {33'd0, add_c};
  end

  // Control counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      div_q  <= ctl_i.is_div;
      cnt_q  <= ctl_i.is_div ? 7'd63 : 7'd31;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath registers, one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      q_q   <= opa_i;
      b_q   <= opb_i;
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= sum[33] ? sum[31:0] : {acc_q[30:0], q_q[63]};
        q_q   <= {q_q[62:0], sum[33]};
      end else begin
        acc_q       <= sum[32:1];
        q_q[31:0]   <= {sum[0], q_q[31:1]};
      end
    end
  end

  // The last step is taken combinationally in the cycle that reports done.
  assign done_o = busy_q && (cnt_q == 7'd0);
  assign acc_o  = div_q ? (sum[33] ? sum[31:0] : {acc_q[30:0], q_q[63]}) : sum[32:1];
  assign quo_o  = div_q ? {q_q[62:0], sum[33]} : {32'd0, sum[0], q_q[31:1]};

endmodule

### test/forth_stack_alu_core_tb.sv
// Testbench for the Forth stack ALU core: directed and random items against a predictor.
`timescale 1ns / 1ps
module forth_stack_alu_core_tb;

  typedef struct packed {
    logic [31:0] top_value;
    logic [31:0] second_value;
    logic [4:0]  data_count;
    logic [4:0]  return_count;
    logic [2:0]  status;
  } stack_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fsac_in_if  in_ch ();
  fsac_out_if out_ch ();

  forth_stack_alu_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0] p_top;
  logic [31:0] p_data [fsac_pkg::DATA_DEPTH];
  logic [31:0] p_ret [fsac_pkg::RETURN_DEPTH];
  int unsigned p_dp;
  int unsigned p_rp;

  stack_view_t expected_views[$];
  int          fail_count = 0;
  bit          calm = 1'b0;

  function automatic logic [31:0] below_top(int unsigned k);
    if (k == 0 || k > p_dp) return 32'd0;
    return p_data[(p_dp - k) % fsac_pkg::DATA_DEPTH];
  endfunction

  function automatic void put_below(int unsigned k, logic [31:0] v);
    if (k == 0 || k > p_dp) return;
    p_data[(p_dp - k) % fsac_pkg::DATA_DEPTH] = v;
  endfunction

  function automatic void push_top(logic [31:0] v);
    p_data[p_dp % fsac_pkg::DATA_DEPTH] = p_top;
    p_dp++;
    p_top = v;
  endfunction

  function automatic void pop_top();
    p_dp--;
    p_top = p_data[p_dp % fsac_pkg::DATA_DEPTH];
  endfunction

  function automatic fsac_pkg::status_e check_depth(int unsigned n, bit push);
    if (p_dp < n) return fsac_pkg::ST_UNDER;
    if (push && p_dp >= fsac_pkg::DATA_DEPTH) return fsac_pkg::ST_OVER;
    return fsac_pkg::ST_OK;
  endfunction

  // Works out the view after one action and updates the predictor state.
  function automatic stack_view_t stack_step(logic [4:0] act, logic [31:0] lit);
    fsac_pkg::status_e st;
    logic [31:0] t;
    logic [31:0] s;
    logic [31:0] r;
    logic [63:0] d;
    logic [63:0] q;
    stack_view_t v;
    st = fsac_pkg::ST_OK;
    t = p_top;
    s = below_top(1);
    case (act)
      fsac_pkg::ACT_DUP: begin
        st = check_depth(0, 1);
        if (st == fsac_pkg::ST_OK) push_top(t);
      end
      fsac_pkg::ACT_DROP: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) pop_top();
      end
      fsac_pkg::ACT_SWAP: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) begin
          put_below(1, t);
          p_top = s;
        end
      end
      fsac_pkg::ACT_OVER: begin
        st = check_depth(1, 1);
        if (st == fsac_pkg::ST_OK) push_top(s);
      end
      fsac_pkg::ACT_ADD, fsac_pkg::ACT_SUB, fsac_pkg::ACT_AND, fsac_pkg::ACT_OR,
      fsac_pkg::ACT_XOR, fsac_pkg::ACT_LSHIFT, fsac_pkg::ACT_RSHIFT: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) begin
          case (act)
            fsac_pkg::ACT_ADD: r = s + t;
            fsac_pkg::ACT_SUB: r = s - t;
            fsac_pkg::ACT_AND: r = s & t;
            fsac_pkg::ACT_OR:  r = s | t;
            fsac_pkg::ACT_XOR: r = s ^ t;
            fsac_pkg::ACT_LSHIFT: r = (t >= 32) ? 32'd0 : s << t[4:0];
            default: r = (t >= 32) ? 32'd0 : s >> t[4:0];
          endcase
          pop_top();
          p_top = r;
        end
      end
      fsac_pkg::ACT_INVERT: p_top = ~t;
      fsac_pkg::ACT_NEGATE: p_top = 32'd0 - t;
      fsac_pkg::ACT_ABS: if (t[31]) p_top = 32'd0 - t;
      fsac_pkg::ACT_SHL1: p_top = t << 1;
      fsac_pkg::ACT_SHR1: p_top = t >> 1;
      fsac_pkg::ACT_UMUL: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) begin
          d = 64'(s) * 64'(t);
          put_below(1, d[31:0]);
          p_top = d[63:32];
        end
      end
      fsac_pkg::ACT_UDIVMOD: begin
        st = check_depth(2, 0);
        if (st == fsac_pkg::ST_OK && t == 0) st = fsac_pkg::ST_DIVZ;
        if (st == fsac_pkg::ST_OK) begin
          d = {s, below_top(2)};
          q = d / 64'(t);
          r = 32'(d % 64'(t));
          if (q[63:32] != 0) st = fsac_pkg::ST_QOVF;
          p_dp--;
          put_below(1, r);
          p_top = q[31:0];
        end
      end
      fsac_pkg::ACT_DNEGATE: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) begin
          d = 64'd0 - {t, s};
          put_below(1, d[31:0]);
          p_top = d[63:32];
        end
      end
      fsac_pkg::ACT_NIP: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK) p_dp--;
      end
      fsac_pkg::ACT_DEPTH: begin
        st = check_depth(0, 1);
        if (st == fsac_pkg::ST_OK) push_top(32'(p_dp));
      end
      fsac_pkg::ACT_LITERAL: begin
        st = check_depth(0, 1);
        if (st == fsac_pkg::ST_OK) push_top(lit);
      end
      fsac_pkg::ACT_TOR: begin
        st = check_depth(1, 0);
        if (st == fsac_pkg::ST_OK && p_rp >= fsac_pkg::RETURN_DEPTH) st = fsac_pkg::ST_OVER;
        if (st == fsac_pkg::ST_OK) begin
          p_ret[p_rp % fsac_pkg::RETURN_DEPTH] = t;
          p_rp++;
          pop_top();
        end
      end
      fsac_pkg::ACT_RFROM, fsac_pkg::ACT_RFETCH: begin
        if (p_rp == 0) st = fsac_pkg::ST_UNDER;
        else st = check_depth(0, 1);
        if (st == fsac_pkg::ST_OK) begin
          r = p_ret[(p_rp - 1) % fsac_pkg::RETURN_DEPTH];
          if (act == fsac_pkg::ACT_RFROM) p_rp--;
          push_top(r);
        end
      end
      fsac_pkg::ACT_RESET: begin
        p_top = 32'd0;
        p_dp = 0;
        p_rp = 0;
      end
      default: ;
    endcase
    v.top_value = p_top;
    v.second_value = below_top(1);
    v.data_count = 5'(p_dp);
    v.return_count = 5'(p_rp);
    v.status = st;
    return v;
  endfunction

  function automatic bit chance_idle();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  // Sends one item, with random gaps before it; valid stays up until the next falling edge.
  task automatic send_item(logic [4:0] act, logic [31:0] lit);
    @(negedge clk_i);
    while (chance_idle()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.literal <= lit;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_views.push_back(stack_step(act, lit));
  endtask

  // Drops valid and waits until every expected result has come.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Result checker and random backpressure.
  always @(negedge clk_i) out_ch.ready <= !chance_idle();

  always @(posedge clk_i) begin
    stack_view_t ev;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_views.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        ev = expected_views.pop_front();
        if (out_ch.top_value !== ev.top_value) begin
          $error("top_value exp %h got %h", ev.top_value, out_ch.top_value);
          fail_count++;
        end
        if (out_ch.second_value !== ev.second_value) begin
          $error("second_value exp %h got %h", ev.second_value, out_ch.second_value);
          fail_count++;
        end
        if (out_ch.data_count !== ev.data_count) begin
          $error("data_count exp %0d got %0d", ev.data_count, out_ch.data_count);
          fail_count++;
        end
        if (out_ch.return_count !== ev.return_count) begin
          $error("return_count exp %0d got %0d", ev.return_count, out_ch.return_count);
          fail_count++;
        end
        if (out_ch.status !== ev.status) begin
          $error("status exp %0d got %0d", ev.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // Directed: underflow from empty, extremes, a selection of actions, overflow, divide cases.
  task automatic test_directed();
    int i;
    send_item(fsac_pkg::ACT_DROP, 32'd0);
    send_item(fsac_pkg::ACT_RFROM, 32'd0);
    send_item(fsac_pkg::ACT_UDIVMOD, 32'd0);
    send_item(fsac_pkg::ACT_LITERAL, 32'hffff_ffff);
    send_item(fsac_pkg::ACT_LITERAL, 32'hffff_ffff);
    send_item(fsac_pkg::ACT_UMUL, 32'd0);
    send_item(fsac_pkg::ACT_DNEGATE, 32'd0);
    send_item(fsac_pkg::ACT_LITERAL, 32'd1);
    send_item(fsac_pkg::ACT_UDIVMOD, 32'd0);
    send_item(fsac_pkg::ACT_LITERAL, 32'd0);
    send_item(fsac_pkg::ACT_UDIVMOD, 32'd0);
    send_item(fsac_pkg::ACT_LITERAL, 32'd32);
    send_item(fsac_pkg::ACT_LSHIFT, 32'd0);
    send_item(fsac_pkg::ACT_LITERAL, 32'h8000_0000);
    send_item(fsac_pkg::ACT_ABS, 32'd0);
    send_item(fsac_pkg::ACT_TOR, 32'd0);
    send_item(fsac_pkg::ACT_RFETCH, 32'd0);
    send_item(fsac_pkg::ACT_RFROM, 32'd0);
    for (i = 0; i < 18; i++) send_item(fsac_pkg::ACT_DEPTH, 32'd0);
    send_item(fsac_pkg::ACT_OVER, 32'd0);
    send_item(5'd31, 32'd0);
    send_item(fsac_pkg::ACT_RESET, 32'd0);
  endtask

  // Random: mostly legal actions at random depths with random words.
  task automatic test_random(int n);
    int i;
    logic [4:0]  act;
    logic [31:0] lit;
    for (i = 0; i < n; i++) begin
      calm = (i >= 300 && i < 450);
      case ($urandom_range(9))
        0, 1, 2: act = fsac_pkg::ACT_LITERAL;
        3: act = 5'($urandom_range(31));
        4: act = $urandom_range(1) ? fsac_pkg::ACT_UDIVMOD : fsac_pkg::ACT_UMUL;
        5: act = 5'($urandom_range(fsac_pkg::ACT_TOR, fsac_pkg::ACT_RFETCH));
        default: act = 5'($urandom_range(fsac_pkg::ACT_DNEGATE));
      endcase
      if (act == fsac_pkg::ACT_RESET && $urandom_range(3) != 0) act = fsac_pkg::ACT_SWAP;
      case ($urandom_range(3))
        0: lit = $urandom_range(40);
        1: lit = $urandom_range(1) ? 32'hffff_ffff : 32'h8000_0000;
        default: lit = $urandom;
      endcase
      send_item(act, lit);
    end
    calm = 1'b0;
  endtask

  // Pause until the block has drained, then keep going.
  task automatic test_drain_pause();
    wait_drained();
    test_random(600);
  endtask

  initial begin
    p_top = 32'd0;
    p_dp = 0;
    p_rp = 0;
    foreach (p_data[i]) p_data[i] = 32'd0;
    foreach (p_ret[i]) p_ret[i] = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.literal = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(700);
    test_drain_pause();
    wait_drained();
    if (fail_count == 0) $display("PASS forth_stack_alu_core");
    else $display("FAIL forth_stack_alu_core");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL forth_stack_alu_core");
    $finish;
  end
endmodule
